// ===== sv/ppm_channel_decoder_macros.svh =====
// -----------------------------------------------------------------------------
// ppm channel decoder assertion macros
// shared concurrent assertion forms, reset-qualified
// -----------------------------------------------------------------------------
`ifndef PPM_CHANNEL_DECODER_MACROS_SVH
`define PPM_CHANNEL_DECODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PPM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppm decoder check failed");

// antecedent implies consequent in the next cycle
`define PPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppm decoder check failed");

`endif

// ===== sv/ppm_pkg.sv =====
// -----------------------------------------------------------------------------
// ppm_pkg
// shared constants, types and helpers of the ppm channel decoder
// -----------------------------------------------------------------------------
`default_nettype none

package ppm_pkg;

   localparam int CHANNELS  = 8;
   localparam int MAX_OUT   = 8;
   localparam int CH_LIMIT  = (CHANNELS > MAX_OUT) ? MAX_OUT : CHANNELS;
   localparam int SLOT_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W     = 4;
   localparam int REG_W     = 16;
   localparam int ADDR_W    = 2;
   localparam int TICK_W    = 16;
   localparam int FINE_W    = 9;
   localparam int GAP_W     = 24;
   localparam int DIFF_W    = 11;
   localparam int POS_W     = 8;
   localparam int IDX_W     = 3;

   localparam logic [GAP_W-1:0]  TICK_US      = GAP_W'(200);
   localparam logic [15:0]       RECIP_5      = 16'hCCCD;   // floor(x/5) = x*RECIP_5 >> 18
   localparam logic [GAP_W-1:0]  POS_SAT_DIFF = GAP_W'(1280);
   localparam logic [TICK_W-1:0] TICK_MAX     = '1;

   localparam logic [REG_W-1:0] SYNC_RESET   = REG_W'(3000);
   localparam logic [REG_W-1:0] OFFSET_RESET = REG_W'(1000);
   localparam logic [CNT_W-1:0] COUNT_RESET  = CNT_W'(8);

   localparam logic [ADDR_W-1:0] REG_SYNC_THRESHOLD = 2'd0;
   localparam logic [ADDR_W-1:0] REG_PULSE_OFFSET   = 2'd1;
   localparam logic [ADDR_W-1:0] REG_CHANNEL_COUNT  = 2'd2;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_EDGE = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef enum logic {
      OP_STORE = 1'b0,
      OP_BURST = 1'b1
   } op_type;

   typedef struct packed {
      logic [REG_W-1:0] sync_threshold_us;
      logic [REG_W-1:0] pulse_offset_us;
      logic [CNT_W-1:0] channel_count;
   } cfg_type;

   typedef struct packed {
      op_type            op;
      logic [SLOT_W-1:0] slot;
      logic [POS_W-1:0]  value;
      logic [CNT_W-1:0]  count;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // channel count as used: zero acts as one, large values clip to the store
   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cc);
      logic [CNT_W-1:0] n;
      n = cc;
      if (n == '0) begin
         n = CNT_W'(1);
      end
      if (n > CNT_W'(CH_LIMIT)) begin
         n = CNT_W'(CH_LIMIT);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ppm_front.sv =====
// -----------------------------------------------------------------------------
// ppm_front
// accepts ticks and edges, forms the gap and classifies each edge
// -----------------------------------------------------------------------------
`default_nettype none

module ppm_front (
   input  wire                  clock,
   input  wire                  reset,
   input  ppm_pkg::cfg_type     cfg,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  wire                  in_cmd,
   input  wire  [8:0]           in_fine,
   output logic                 push_valid,
   input  wire                  push_ready,
   output ppm_pkg::q_entry_type push_data
);
   import ppm_pkg::*;

   typedef enum logic [3:0] {
      F_IDLE  = 4'b0001,
      F_SUM   = 4'b0010,
      F_CLASS = 4'b0100,
      F_PUSH  = 4'b1000
   } fstate_type;

   fstate_type         state_ff, state_in;
   logic [TICK_W-1:0]  tick_count_ff, tick_count_in;
   logic [CNT_W-1:0]   slot_index_ff, slot_index_in;
   logic [GAP_W-1:0]   coarse_ff, coarse_in;
   logic [FINE_W-1:0]  fine5_ff, fine5_in;
   logic [GAP_W-1:0]   gap_ff, gap_in;
   logic               sync_ff, sync_in;
   logic               sat_ff, sat_in;
   logic [DIFF_W-1:0]  diff_ff, diff_in;

   logic [26:0]        fine_prod;
   logic [26:0]        pos_prod;
   logic [GAP_W-1:0]   gap_less;
   logic [CNT_W-1:0]   n_eff;
   logic [POS_W-1:0]   pos;
   logic               want_push;

   assign in_ready  = (state_ff == F_IDLE);
   assign n_eff     = eff_count(cfg.channel_count);
   assign fine_prod = 27'({in_fine, 2'b00}) * 27'(RECIP_5);
   assign gap_less  = gap_ff - GAP_W'(cfg.pulse_offset_us);
   assign pos_prod  = 27'(diff_ff) * 27'(RECIP_5);
   assign pos       = sat_ff ? '1 : pos_prod[25:18];
   assign want_push = sync_ff || (slot_index_ff < n_eff);

   always_comb begin
      state_in      = state_ff;
      tick_count_in = tick_count_ff;
      slot_index_in = slot_index_ff;
      coarse_in     = coarse_ff;
      fine5_in      = fine5_ff;
      gap_in        = gap_ff;
      sync_in       = sync_ff;
      sat_in        = sat_ff;
      diff_in       = diff_ff;
      push_valid    = 1'b0;
      push_data.op    = sync_ff ? OP_BURST : OP_STORE;
      push_data.slot  = slot_index_ff[SLOT_W-1:0];
      push_data.value = pos;
      push_data.count = n_eff;
      unique case (state_ff)
         F_IDLE: begin
            if (in_valid) begin
               if (in_cmd == CMD_TICK) begin
                  if (tick_count_ff != TICK_MAX) begin
                     tick_count_in = tick_count_ff + TICK_W'(1);
                  end
               end else begin
                  coarse_in     = GAP_W'(tick_count_ff) * TICK_US;
                  fine5_in      = fine_prod[26:18];
                  tick_count_in = '0;
                  state_in      = F_SUM;
               end
            end
         end
         F_SUM: begin
            gap_in   = coarse_ff + GAP_W'(fine5_ff);
            state_in = F_CLASS;
         end
         F_CLASS: begin
            sync_in = gap_ff > GAP_W'(cfg.sync_threshold_us);
            // gap at or below the offset gives position zero
            if (gap_ff <= GAP_W'(cfg.pulse_offset_us)) begin
               sat_in  = 1'b0;
               diff_in = '0;
            end else begin
               sat_in  = gap_less >= POS_SAT_DIFF;
               diff_in = gap_less[DIFF_W-1:0];
            end
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!want_push) begin
               state_in = F_IDLE;
            end else begin
               push_valid = 1'b1;
               if (push_ready) begin
                  slot_index_in = sync_ff ? '0 : slot_index_ff + CNT_W'(1);
                  state_in      = F_IDLE;
               end
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         tick_count_ff <= '0;
         slot_index_ff <= '0;
      end else begin
         state_ff      <= state_in;
         tick_count_ff <= tick_count_in;
         slot_index_ff <= slot_index_in;
      end
   end

   always_ff @(posedge clock) begin
      coarse_ff <= coarse_in;
      fine5_ff  <= fine5_in;
      gap_ff    <= gap_in;
      sync_ff   <= sync_in;
      sat_ff    <= sat_in;
      diff_ff   <= diff_in;
   end

endmodule

`default_nettype wire

// ===== sv/ppm_queue.sv =====
// -----------------------------------------------------------------------------
// ppm_queue
// short command queue between classification and execution
// -----------------------------------------------------------------------------
`default_nettype none

module ppm_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push_valid,
   output logic                 push_ready,
   input  ppm_pkg::q_entry_type push_data,
   output logic                 pop_valid,
   input  wire                  pop_ready,
   output ppm_pkg::q_entry_type pop_data,
   output ppm_pkg::q_status_type status
);
   import ppm_pkg::*;

   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

   q_entry_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic               do_push, do_pop;

   assign status.full  = (level_ff == LVL_W'(QUEUE_DEPTH));
   assign status.empty = (level_ff == '0);
   assign push_ready   = !status.full;
   assign pop_valid    = !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];
   assign do_push      = push_valid && push_ready;
   assign do_pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + LVL_W'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ppm_back.sv =====
// -----------------------------------------------------------------------------
// ppm_back
// holds the channel positions, writes them and reads out sync bursts
// -----------------------------------------------------------------------------
`default_nettype none

module ppm_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  pop_valid,
   output logic                 pop_ready,
   input  ppm_pkg::q_entry_type pop_data,
   output logic                 out_valid,
   input  wire                  out_ready,
   output logic [2:0]           out_index,
   output logic [7:0]           out_value,
   output logic                 out_last
);
   import ppm_pkg::*;

   typedef enum logic [1:0] {
      B_IDLE  = 2'b01,
      B_BURST = 2'b10
   } bstate_type;

   bstate_type        state_ff, state_in;
   logic [POS_W-1:0]  store_ff [CHANNELS];
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              valid_ff, valid_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   logic [POS_W-1:0]  value_ff, value_in;
   logic              last_ff, last_in;
   logic              out_free;
   logic              is_last;
   logic              do_write;

   assign pop_ready = (state_ff == B_IDLE);
   assign out_free  = !valid_ff || out_ready;
   assign is_last   = (k_ff + CNT_W'(1)) == count_ff;
   assign do_write  = pop_valid && pop_ready && (pop_data.op == OP_STORE);
   assign out_valid = valid_ff;
   assign out_index = index_ff;
   assign out_value = value_ff;
   assign out_last  = last_ff;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      count_in = count_ff;
      valid_in = valid_ff && !out_ready;
      index_in = index_ff;
      value_in = value_ff;
      last_in  = last_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid && pop_data.op == OP_BURST) begin
               k_in     = '0;
               count_in = pop_data.count;
               state_in = B_BURST;
            end
         end
         B_BURST: begin
            // one channel per cycle into the output register, while it is free
            if (out_free) begin
               valid_in = 1'b1;
               index_in = k_ff[IDX_W-1:0];
               value_in = store_ff[k_ff[SLOT_W-1:0]];
               last_in  = is_last;
               k_in     = k_ff + CNT_W'(1);
               if (is_last) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (do_write) begin
            store_ff[pop_data.slot] <= pop_data.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      count_ff <= count_in;
      index_ff <= index_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

endmodule

`default_nettype wire

// ===== sv/ppm_channel_decoder.sv =====
// -----------------------------------------------------------------------------
// ppm_channel_decoder
// rc pulse-position decoder: ticks and edges in, channel positions out
// -----------------------------------------------------------------------------
// channel   ports                          carries
// req       req_tvalid/tready/tdata/tuser  tuser: command, tdata[8:0]: fine_count
// rsp       rsp_tvalid/tready/tdata/tlast  tdata[2:0]: index, [10:3]: value
// csr       csr_we/csr_addr/csr_wdata      register writes, no read-back
//
// a tick leaves the front ready; an edge holds the input busy in the
// front (product, gap sum, classify, enqueue), longer if the queue is full.
// a sync burst drains from the back at one channel per cycle of a free
// output register and stalls while rsp_tready is low.
// reset is synchronous; it clears the tick count, slot index and positions.
// -----------------------------------------------------------------------------
`default_nettype none

module ppm_channel_decoder (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,    // [8:0] fine_count
   input  wire         req_tuser,    // [0] command
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,    // [2:0] channel_index, [10:3] channel_value
   output logic        rsp_tlast,
   input  wire         csr_we,
   input  wire  [1:0]  csr_addr,
   input  wire  [15:0] csr_wdata
);
   import ppm_pkg::*;

   `include "ppm_channel_decoder_macros.svh"

   cfg_type      cfg_ff, cfg_in;
   logic         push_valid, push_ready;
   q_entry_type  push_data;
   logic         pop_valid, pop_ready;
   q_entry_type  pop_data;
   q_status_type q_status;
   logic [2:0]   out_index;
   logic [7:0]   out_value;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_SYNC_THRESHOLD: cfg_in.sync_threshold_us = csr_wdata;
            REG_PULSE_OFFSET:   cfg_in.pulse_offset_us   = csr_wdata;
            REG_CHANNEL_COUNT:  cfg_in.channel_count     = csr_wdata[CNT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_threshold_us <= SYNC_RESET;
         cfg_ff.pulse_offset_us   <= OFFSET_RESET;
         cfg_ff.channel_count     <= COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_cmd     (req_tuser),
      .in_fine    (req_tdata[8:0]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ppm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .status     (q_status)
   );

   ppm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_index  (out_index),
      .out_value  (out_value),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, out_value, out_index};

   // an edge transaction keeps the front busy on the next cycle
   `PPM_ASSERT_NEXT(a_edge_busy, clock, reset, req_tvalid && req_tready && req_tuser, !req_tready)
   // a tick transaction leaves the front ready again
   `PPM_ASSERT_NEXT(a_tick_ready, clock, reset, req_tvalid && req_tready && !req_tuser, req_tready)
   // queue cannot be full and empty at once
   `PPM_ASSERT_IMPL(a_queue_sane, clock, reset, 1'b1, !(q_status.full && q_status.empty))

endmodule

`default_nettype wire
